FILE: src/rmts_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the rate-monotonic tick scheduler.
package rmts_pkg;

	localparam int FIELD_W   = 16;
	localparam int TASK_W    = 2;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;
	localparam int TCNT_W    = 3;
	localparam int CNT_OUT_W = 5;
	localparam int TOTAL_W   = 32;
	localparam int IN_W      = 8;
	localparam int OUT_W     = 80;

	localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIODS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BUDGETS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEADLINES  = 2'd3;

	// Operation that every queue cell performs in the current cycle
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INSERT,
		OP_MARK,
		OP_SHIFT,
		OP_DEC
	} cell_op_t;

	// Phases of one scheduler tick
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INSERT,
		ST_MARK,
		ST_SWEEP,
		ST_RUN,
		ST_OUT
	} tick_state_t;

	// Broadcast control from the sequencer to the cell row
	typedef struct packed {
		cell_op_t               op;
		logic [FIELD_W-1:0]     new_period;
		logic [TASK_W-1:0]      ins_task;
		logic [FIELD_W-1:0]     new_remaining;
	} cell_ctl_t;

	// Pick the 16-bit field of task t out of a packed register
	function automatic logic [FIELD_W-1:0] field16(input logic [CFG_W-1:0] vec,
			input logic [TASK_W-1:0] t);
		return vec[t*FIELD_W +: FIELD_W];
	endfunction

endpackage

FILE: src/rmts_cell.sv
`timescale 1ns / 1ps
// One slot of the job queue: holds a job and trades it with its neighbors.
module rmts_cell #(
	parameter int IDX         = 0,
	parameter int QUEUE_DEPTH = 16,
	parameter int TIME_BITS   = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rmts_pkg::cell_ctl_t             ctl,
	input  logic [TIME_BITS-1:0]            new_deadline,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
	input  logic [rmts_pkg::CFG_W-1:0]      periods,
	input  logic [TIME_BITS-1:0]            now,
	input  logic                            left_grt,
	input  logic [rmts_pkg::TASK_W-1:0]     left_task,
	input  logic [rmts_pkg::FIELD_W-1:0]    left_rem,
	input  logic [TIME_BITS-1:0]            left_dl,
	input  logic                            kill_in,
	input  logic [rmts_pkg::TASK_W-1:0]     right_task,
	input  logic [rmts_pkg::FIELD_W-1:0]    right_rem,
	input  logic [TIME_BITS-1:0]            right_dl,
	input  logic                            right_doomed,
	output logic [rmts_pkg::TASK_W-1:0]     task_id,
	output logic [rmts_pkg::FIELD_W-1:0]    rem,
	output logic [TIME_BITS-1:0]            dl,
	output logic                            doomed,
	output logic                            grt,
	output logic                            kill_out
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [rmts_pkg::TASK_W-1:0]  task_q;
	logic [rmts_pkg::FIELD_W-1:0] rem_q;
	logic [TIME_BITS-1:0]         dl_q;
	logic                         doomed_q;
	logic                         occ;
	logic                         at_tail;
	logic [rmts_pkg::FIELD_W-1:0] my_period;

	// Slot holds a job when it sits below the fill count
	assign occ       = CNT_W'(IDX) < count;
	assign at_tail   = CNT_W'(IDX) == count;
	assign my_period = rmts_pkg::field16(periods, task_q);

	// Slot gives way once the insertion point lies here or closer to the head;
	// the first job with a strictly longer period marks that point
	assign grt      = left_grt | (occ && (ctl.new_period < my_period));
	// Removal point: this slot or one to its left is dropped
	assign kill_out = kill_in | doomed_q;

	// Job payload: insert, shift out, run
	always_ff @(posedge clk) begin
		case (ctl.op)
			rmts_pkg::OP_INSERT: begin
				if (left_grt) begin
					task_q <= left_task;
					rem_q  <= left_rem;
					dl_q   <= left_dl;
				end else if (grt || at_tail) begin
					task_q <= ctl.ins_task;
					rem_q  <= ctl.new_remaining;
					dl_q   <= new_deadline;
				end
			end
			rmts_pkg::OP_SHIFT: begin
				if (kill_out) begin
					task_q <= right_task;
					rem_q  <= right_rem;
					dl_q   <= right_dl;
				end
			end
			rmts_pkg::OP_DEC: begin
				if (IDX == 0) begin
					rem_q <= rem_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Deadline flag: set on mark, travels with the job on a shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			doomed_q <= 1'b0;
		end else begin
			case (ctl.op)
				rmts_pkg::OP_MARK: doomed_q <= occ && (now >= dl_q);
				rmts_pkg::OP_SHIFT: begin
					if (kill_out) begin
						doomed_q <= right_doomed;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign task_id = task_q;
	assign rem     = rem_q;
	assign dl      = dl_q;
	assign doomed  = doomed_q;

endmodule

FILE: src/rmts_residue.sv
`timescale 1ns / 1ps
// Per-task phase counters (time modulo period) with a serial remainder unit.
module rmts_residue #(
	parameter int NUM_TASKS = 4,
	parameter int TIME_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rmts_pkg::CFG_W-1:0] periods,
	input  logic [TIME_BITS-1:0]       now,
	input  logic                       advance,
	input  logic                       wrap,
	output logic                       busy,
	output logic [NUM_TASKS-1:0]       release_due
);

	localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int BW = $clog2(TIME_BITS);

	logic [rmts_pkg::FIELD_W-1:0] res_q [NUM_TASKS];
	logic                         busy_q;
	logic [TW-1:0]                k_q;
	logic [BW-1:0]                bit_q;
	logic [rmts_pkg::FIELD_W-1:0] acc_q;
	logic [rmts_pkg::FIELD_W-1:0] div_p;
	logic [rmts_pkg::FIELD_W:0]   shifted;
	logic [rmts_pkg::FIELD_W:0]   diff;
	logic [rmts_pkg::FIELD_W-1:0] acc_d;
	logic                         step_last;

	// One restoring-division bit per cycle, time MSB first
	assign div_p     = rmts_pkg::field16(periods, rmts_pkg::TASK_W'(k_q));
	assign shifted   = {acc_q, now[bit_q]};
	assign diff      = shifted - {1'b0, div_p};
	assign acc_d     = (shifted >= {1'b0, div_p}) ? diff[rmts_pkg::FIELD_W-1:0]
	                                               : shifted[rmts_pkg::FIELD_W-1:0];
	assign step_last = busy_q && (bit_q == '0);

	// Sequence over tasks and time bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
			bit_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			k_q    <= '0;
			bit_q  <= BW'(TIME_BITS - 1);
		end else if (busy_q) begin
			if (bit_q == '0) begin
				bit_q <= BW'(TIME_BITS - 1);
				if (k_q == TW'(NUM_TASKS - 1)) begin
					busy_q <= 1'b0;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end else begin
				bit_q <= bit_q - 1'b1;
			end
		end
	end

	// Partial remainder
	always_ff @(posedge clk) begin
		if (start || step_last) begin
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_d;
		end
	end

	// Phase per task: load from divider, else advance by one tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NUM_TASKS; t++) begin
				res_q[t] <= '0;
			end
		end else if (step_last) begin
			res_q[k_q] <= acc_d;
		end else if (advance) begin
			for (int t = 0; t < NUM_TASKS; t++) begin
				if (wrap || ({1'b0, res_q[t]} + 1'b1 ==
						{1'b0, rmts_pkg::field16(periods, rmts_pkg::TASK_W'(t))})) begin
					res_q[t] <= '0;
				end else begin
					res_q[t] <= res_q[t] + 1'b1;
				end
			end
		end
	end

	// Task releases when its period is nonzero and divides the time
	always_comb begin
		for (int t = 0; t < NUM_TASKS; t++) begin
			release_due[t] = (rmts_pkg::field16(periods, rmts_pkg::TASK_W'(t)) != '0)
			                 && (res_q[t] == '0);
		end
	end

	assign busy = busy_q;

endmodule

FILE: src/rate_monotonic_tick_scheduler.sv
`timescale 1ns / 1ps
// Rate-monotonic tick scheduler: sequencer, job queue cell row and outputs.
//
// Each beat on s_axis is one scheduler tick; s_axis_tdata[0] is last_tick.
// Each tick yields one result beat on m_axis, fields from bit 0 up:
// running_task[1:0], idle[2], job_finished[3], deadlines_missed[8:4],
// jobs_killed[13:9], overflow[14], total_missed[46:15],
// total_completed[78:47], zero pad[79].
// Registers are written on the cfg channel (index 0 task_count, 1 periods,
// 2 budgets, 3 deadlines); cfg_ready is always high.
// From accept to result a tick goes through release insertion per task,
// a mark of expired jobs, a sweep that drops them and compacts the queue,
// a run of the head job and the posting of the result. A new tick is
// accepted once the sequencer is back in idle after posting the result.
// A periods write restarts the phase counters: a serial remainder runs over
// every task and time bit, during which s_axis_tready stays low.
// Reset empties the queue, zeroes time and totals, task_count becomes 1.
// A stalled m_axis holds the result in its output register; the block still
// takes the next tick and waits before posting it until the slot frees.
module rate_monotonic_tick_scheduler #(
	parameter int NUM_TASKS   = 4,
	parameter int QUEUE_DEPTH = 16,
	parameter int TIME_BITS   = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [rmts_pkg::IN_W-1:0]      s_axis_tdata,   // last_tick[0], pad
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [rmts_pkg::OUT_W-1:0]     m_axis_tdata,   // see head comment
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rmts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rmts_pkg::CFG_W-1:0]     cfg_data
);

	localparam int TW    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int FW    = rmts_pkg::FIELD_W;
	localparam int KW    = rmts_pkg::TASK_W;

	// Configuration registers
	logic [rmts_pkg::TCNT_W-1:0] task_count_q;
	logic [rmts_pkg::CFG_W-1:0]  periods_q;
	logic [rmts_pkg::CFG_W-1:0]  budgets_q;
	logic [rmts_pkg::CFG_W-1:0]  deadlines_q;
	logic                        cfg_we;
	logic                        per_wr;

	// Sequencer state
	rmts_pkg::tick_state_t state_q, state_d;
	logic [TW-1:0]         tidx_q;
	logic [TIME_BITS-1:0]  time_q;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [CNT_W-1:0]      missed_q;
	logic                  last_q;
	logic                  ovf_q;
	logic                  run_idle_q;
	logic                  run_fin_q;
	logic [KW-1:0]         run_task_q;
	logic [rmts_pkg::TOTAL_W-1:0] tot_miss_q, tot_done_q;
	logic [rmts_pkg::TOTAL_W-1:0] tot_miss_d, tot_done_d;
	logic [rmts_pkg::TOTAL_W:0]   miss_sum;
	logic                  out_valid_q;
	logic [rmts_pkg::OUT_W-1:0] out_data_q;

	logic                  in_fire;
	logic                  out_load;
	logic                  res_busy;
	logic [NUM_TASKS-1:0]  release_due;
	logic                  rel_now;
	logic                  full;
	logic                  has_job;
	logic                  head_fin;
	logic                  any_doomed;
	logic                  kill_seed;
	logic [rmts_pkg::CNT_OUT_W-1:0] miss_sat, kill_sat;
	logic [CNT_W-1:0]      killed;

	rmts_pkg::cell_ctl_t   ctl;
	rmts_pkg::cell_op_t    cell_op;
	logic [TIME_BITS-1:0]  new_deadline;

	// Cell row wiring
	logic [KW-1:0]          c_task [QUEUE_DEPTH];
	logic [FW-1:0]          c_rem  [QUEUE_DEPTH];
	logic [TIME_BITS-1:0]   c_dl   [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] c_doomed;
	logic [QUEUE_DEPTH-1:0] c_grt;
	logic [QUEUE_DEPTH-1:0] c_kill;

	// Configuration write port
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign per_wr    = cfg_we && (cfg_index == rmts_pkg::REG_PERIODS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= rmts_pkg::TCNT_W'(1);
			periods_q    <= '0;
			budgets_q    <= '0;
			deadlines_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rmts_pkg::REG_TASK_COUNT: task_count_q <= cfg_data[rmts_pkg::TCNT_W-1:0];
				rmts_pkg::REG_PERIODS:    periods_q    <= cfg_data;
				rmts_pkg::REG_BUDGETS:    budgets_q    <= cfg_data;
				rmts_pkg::REG_DEADLINES:  deadlines_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Phase counters decide which tasks release this tick
	rmts_residue #(
		.NUM_TASKS(NUM_TASKS),
		.TIME_BITS(TIME_BITS)
	) u_residue (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (per_wr),
		.periods    (periods_q),
		.now        (time_q),
		.advance    (out_load),
		.wrap       (&time_q),
		.busy       (res_busy),
		.release_due(release_due)
	);

	// Handshakes
	assign s_axis_tready = (state_q == rmts_pkg::ST_IDLE) && !res_busy && !per_wr;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == rmts_pkg::ST_OUT) && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Status derived from the queue
	assign rel_now    = release_due[tidx_q] && (rmts_pkg::TCNT_W'(tidx_q) < task_count_q);
	assign full       = count_q == CNT_W'(QUEUE_DEPTH);
	assign has_job    = count_q != '0;
	assign head_fin   = c_rem[0] == FW'(1);
	assign any_doomed = c_kill[QUEUE_DEPTH-1];

	// Job offered to the row during insertion
	assign ctl.op            = cell_op;
	assign ctl.new_period    = rmts_pkg::field16(periods_q, KW'(tidx_q));
	assign ctl.ins_task      = KW'(tidx_q);
	assign ctl.new_remaining = rmts_pkg::field16(budgets_q, KW'(tidx_q));
	assign new_deadline      = time_q +
	                           TIME_BITS'(rmts_pkg::field16(deadlines_q, KW'(tidx_q)));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rmts_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = rmts_pkg::ST_INSERT;
				end
			end
			rmts_pkg::ST_INSERT: begin
				if (tidx_q == TW'(NUM_TASKS - 1)) begin
					state_d = rmts_pkg::ST_MARK;
				end
			end
			rmts_pkg::ST_MARK:  state_d = rmts_pkg::ST_SWEEP;
			rmts_pkg::ST_SWEEP: begin
				if (!any_doomed) begin
					state_d = rmts_pkg::ST_RUN;
				end
			end
			rmts_pkg::ST_RUN: state_d = rmts_pkg::ST_OUT;
			rmts_pkg::ST_OUT: begin
				if (out_load) begin
					state_d = rmts_pkg::ST_IDLE;
				end
			end
			default: state_d = rmts_pkg::ST_IDLE;
		endcase
	end

	// Cell operation and fill count per state
	always_comb begin
		cell_op   = rmts_pkg::OP_HOLD;
		kill_seed = 1'b0;
		count_d   = count_q;
		case (state_q)
			rmts_pkg::ST_INSERT: begin
				if (rel_now && !full) begin
					cell_op = rmts_pkg::OP_INSERT;
					count_d = count_q + 1'b1;
				end
			end
			rmts_pkg::ST_MARK: cell_op = rmts_pkg::OP_MARK;
			rmts_pkg::ST_SWEEP: begin
				if (any_doomed) begin
					cell_op = rmts_pkg::OP_SHIFT;
					count_d = count_q - 1'b1;
				end
			end
			rmts_pkg::ST_RUN: begin
				if (has_job) begin
					if (head_fin) begin
						cell_op   = rmts_pkg::OP_SHIFT;
						kill_seed = 1'b1;
						count_d   = count_q - 1'b1;
					end else begin
						cell_op = rmts_pkg::OP_DEC;
					end
				end
			end
			rmts_pkg::ST_OUT: begin
				if (out_load && last_q) begin
					count_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// Row of queue cells, head at index 0
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                 l_grt;
		logic [KW-1:0]        l_task;
		logic [FW-1:0]        l_rem;
		logic [TIME_BITS-1:0] l_dl;
		logic                 k_in;
		logic [KW-1:0]        r_task;
		logic [FW-1:0]        r_rem;
		logic [TIME_BITS-1:0] r_dl;
		logic                 r_doomed;

		if (i == 0) begin : g_head
			assign l_grt  = 1'b0;
			assign l_task = ctl.ins_task;
			assign l_rem  = ctl.new_remaining;
			assign l_dl   = new_deadline;
			assign k_in   = kill_seed;
		end else begin : g_body
			assign l_grt  = c_grt[i-1];
			assign l_task = c_task[i-1];
			assign l_rem  = c_rem[i-1];
			assign l_dl   = c_dl[i-1];
			assign k_in   = c_kill[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign r_task   = '0;
			assign r_rem    = '0;
			assign r_dl     = '0;
			assign r_doomed = 1'b0;
		end else begin : g_inner
			assign r_task   = c_task[i+1];
			assign r_rem    = c_rem[i+1];
			assign r_dl     = c_dl[i+1];
			assign r_doomed = c_doomed[i+1];
		end

		rmts_cell #(
			.IDX        (i),
			.QUEUE_DEPTH(QUEUE_DEPTH),
			.TIME_BITS  (TIME_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.new_deadline(new_deadline),
			.count       (count_q),
			.periods     (periods_q),
			.now         (time_q),
			.left_grt    (l_grt),
			.left_task   (l_task),
			.left_rem    (l_rem),
			.left_dl     (l_dl),
			.kill_in     (k_in),
			.right_task  (r_task),
			.right_rem   (r_rem),
			.right_dl    (r_dl),
			.right_doomed(r_doomed),
			.task_id     (c_task[i]),
			.rem         (c_rem[i]),
			.dl          (c_dl[i]),
			.doomed      (c_doomed[i]),
			.grt         (c_grt[i]),
			.kill_out    (c_kill[i])
		);
	end

	// Running totals, saturating
	assign miss_sum   = {1'b0, tot_miss_q} + (rmts_pkg::TOTAL_W + 1)'(missed_q);
	assign tot_miss_d = miss_sum[rmts_pkg::TOTAL_W] ? '1 : miss_sum[rmts_pkg::TOTAL_W-1:0];
	assign tot_done_d = (run_fin_q && (tot_done_q != '1)) ? tot_done_q + 1'b1 : tot_done_q;

	// Per-tick counts clipped to the result field
	assign killed   = last_q ? count_q : '0;
	assign miss_sat = (32'(missed_q) > 32'd31) ? 5'd31 : rmts_pkg::CNT_OUT_W'(missed_q);
	assign kill_sat = (32'(killed) > 32'd31) ? 5'd31 : rmts_pkg::CNT_OUT_W'(killed);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rmts_pkg::ST_IDLE;
			tidx_q      <= '0;
			count_q     <= '0;
			time_q      <= '0;
			tot_miss_q  <= '0;
			tot_done_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (in_fire) begin
				tidx_q <= '0;
			end else if (state_q == rmts_pkg::ST_INSERT) begin
				tidx_q <= tidx_q + 1'b1;
			end
			if (out_load) begin
				time_q      <= time_q + 1'b1;
				tot_miss_q  <= tot_miss_d;
				tot_done_q  <= tot_done_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Per-tick results and output beat
	always_ff @(posedge clk) begin
		if (in_fire) begin
			last_q   <= s_axis_tdata[0];
			missed_q <= '0;
			ovf_q    <= 1'b0;
		end
		if ((state_q == rmts_pkg::ST_INSERT) && rel_now && full) begin
			ovf_q <= 1'b1;
		end
		if ((state_q == rmts_pkg::ST_SWEEP) && any_doomed) begin
			missed_q <= missed_q + 1'b1;
		end
		if (state_q == rmts_pkg::ST_RUN) begin
			run_idle_q <= !has_job;
			run_fin_q  <= has_job && head_fin;
			run_task_q <= has_job ? c_task[0] : '0;
		end
		if (out_load) begin
			out_data_q <= {1'b0, tot_done_d, tot_miss_d, ovf_q, kill_sat, miss_sat,
			               run_fin_q, run_idle_q, run_task_q};
		end
	end

	// Fill count never passes the queue depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue fill count above depth");

	// Compaction leaves no expired job behind
	a_sweep_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rmts_pkg::ST_SWEEP && !any_doomed) |=> (c_doomed == '0))
		else $error("expired job left in queue after sweep");

	// A granted release grows the queue by exactly one
	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rmts_pkg::ST_INSERT && rel_now && !full)
		|=> (count_q == $past(count_q) + 1'b1))
		else $error("release not added to queue");

	// Last tick leaves an empty queue
	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && last_q) |=> (count_q == '0))
		else $error("queue not flushed on last tick");

endmodule

FILE: sim/rmts_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the rate-monotonic tick scheduler: predicts each tick and checks result beats.
module rmts_checker #(
	parameter int NUM_TASKS   = 4,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [rmts_pkg::IN_W-1:0]      s_axis_tdata,   // last_tick[0], pad
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [rmts_pkg::OUT_W-1:0]     m_axis_tdata,   // running_task, idle, job_finished,
	                                                       // deadlines_missed, jobs_killed,
	                                                       // overflow, total_missed,
	                                                       // total_completed, pad
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [rmts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rmts_pkg::CFG_W-1:0]     cfg_data,
	output int                             mismatches,
	output int                             outstanding
);

	// One result beat; the first member sits in the highest bits
	typedef struct packed {
		logic [rmts_pkg::TOTAL_W-1:0]   total_completed;
		logic [rmts_pkg::TOTAL_W-1:0]   total_missed;
		logic                           overflow;
		logic [rmts_pkg::CNT_OUT_W-1:0] jobs_killed;
		logic [rmts_pkg::CNT_OUT_W-1:0] deadlines_missed;
		logic                           job_finished;
		logic                           idle;
		logic [rmts_pkg::TASK_W-1:0]    running_task;
	} tick_result_t;

	// Shadow registers
	logic [rmts_pkg::TCNT_W-1:0] task_cnt;
	logic [rmts_pkg::CFG_W-1:0]  period_cfg;
	logic [rmts_pkg::CFG_W-1:0]  budget_cfg;
	logic [rmts_pkg::CFG_W-1:0]  deadline_cfg;

	// Shadow scheduler state
	logic [31:0]                  now;
	logic [rmts_pkg::TASK_W-1:0]  job_task [QUEUE_DEPTH];
	logic [rmts_pkg::FIELD_W-1:0] job_left [QUEUE_DEPTH];
	logic [31:0]                  job_due  [QUEUE_DEPTH];
	int                           depth;
	logic [31:0]                  missed_total;
	logic [31:0]                  done_total;

	tick_result_t tick_results_due [$];

	initial begin
		task_cnt     = 3'd1;
		period_cfg   = '0;
		budget_cfg   = '0;
		deadline_cfg = '0;
		now          = '0;
		depth        = 0;
		missed_total = '0;
		done_total   = '0;
		mismatches   = 0;
		outstanding  = 0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 50)
			$display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic apply_register(input logic [rmts_pkg::CFG_IDX_W-1:0] idx,
			input logic [rmts_pkg::CFG_W-1:0] value);
		case (idx)
			rmts_pkg::REG_TASK_COUNT: task_cnt     = value[rmts_pkg::TCNT_W-1:0];
			rmts_pkg::REG_PERIODS:    period_cfg   = value;
			rmts_pkg::REG_BUDGETS:    budget_cfg   = value;
			rmts_pkg::REG_DEADLINES:  deadline_cfg = value;
			default: ;
		endcase
	endtask

	function automatic logic [31:0] sat_add(input logic [31:0] base, input int n);
		logic [32:0] sum;
		sum = {1'b0, base} + 33'(n);
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	// Advance the shadow scheduler by one tick and form the result it owes
	task automatic schedule_tick(input logic last, output tick_result_t res);
		int active, pos, keep, dropped, t, i;
		logic [rmts_pkg::FIELD_W-1:0] per;
		res = '0;
		res.idle = 1'b1;
		active = (int'(task_cnt) > NUM_TASKS) ? NUM_TASKS : int'(task_cnt);

		// release: insert behind every job whose period is not longer
		for (t = 0; t < active; t++) begin
			per = period_cfg[t*rmts_pkg::FIELD_W +: rmts_pkg::FIELD_W];
			if (per != '0 && (now % {16'd0, per}) == 32'd0) begin
				if (depth >= QUEUE_DEPTH) begin
					res.overflow = 1'b1;
				end else begin
					pos = 0;
					while (pos < depth && per >=
							period_cfg[int'(job_task[pos])*rmts_pkg::FIELD_W +: rmts_pkg::FIELD_W])
						pos++;
					for (i = depth; i > pos; i--) begin
						job_task[i] = job_task[i-1];
						job_left[i] = job_left[i-1];
						job_due[i]  = job_due[i-1];
					end
					job_task[pos] = rmts_pkg::TASK_W'(t);
					job_left[pos] = budget_cfg[t*rmts_pkg::FIELD_W +: rmts_pkg::FIELD_W];
					job_due[pos]  = now +
						{16'd0, deadline_cfg[t*rmts_pkg::FIELD_W +: rmts_pkg::FIELD_W]};
					depth++;
				end
			end
		end

		// drop jobs whose deadline has come
		keep = 0;
		dropped = 0;
		for (i = 0; i < depth; i++) begin
			if (now >= job_due[i]) begin
				dropped++;
			end else begin
				job_task[keep] = job_task[i];
				job_left[keep] = job_left[i];
				job_due[keep]  = job_due[i];
				keep++;
			end
		end
		depth = keep;
		missed_total = sat_add(missed_total, dropped);

		// run the head job for one unit
		if (depth > 0) begin
			res.idle = 1'b0;
			res.running_task = job_task[0];
			job_left[0] = job_left[0] - 1'b1;
			if (job_left[0] == '0) begin
				res.job_finished = 1'b1;
				done_total = sat_add(done_total, 1);
				for (i = 1; i < depth; i++) begin
					job_task[i-1] = job_task[i];
					job_left[i-1] = job_left[i];
					job_due[i-1]  = job_due[i];
				end
				depth--;
			end
		end

		// flush on the final tick
		if (last) begin
			res.jobs_killed = (depth > 31) ? 5'd31 : rmts_pkg::CNT_OUT_W'(depth);
			depth = 0;
		end

		res.deadlines_missed = (dropped > 31) ? 5'd31 : rmts_pkg::CNT_OUT_W'(dropped);
		res.total_missed     = missed_total;
		res.total_completed  = done_total;
		now = now + 1'b1;
	endtask

	// Watch the three channels
	always @(posedge clk) begin
		tick_result_t got, want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_register(cfg_index, cfg_data);
			if (s_axis_tvalid && s_axis_tready) begin
				schedule_tick(s_axis_tdata[0], want);
				tick_results_due.push_back(want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = tick_result_t'(m_axis_tdata[$bits(tick_result_t)-1:0]);
				if (tick_results_due.size() == 0) begin
					report_mismatch("result beat with no tick outstanding", 32'd0, 32'd0);
				end else begin
					want = tick_results_due.pop_front();
					if (got.running_task != want.running_task)
						report_mismatch("running_task", 32'(got.running_task),
							32'(want.running_task));
					if (got.idle != want.idle)
						report_mismatch("idle", 32'(got.idle), 32'(want.idle));
					if (got.job_finished != want.job_finished)
						report_mismatch("job_finished", 32'(got.job_finished),
							32'(want.job_finished));
					if (got.deadlines_missed != want.deadlines_missed)
						report_mismatch("deadlines_missed", 32'(got.deadlines_missed),
							32'(want.deadlines_missed));
					if (got.jobs_killed != want.jobs_killed)
						report_mismatch("jobs_killed", 32'(got.jobs_killed),
							32'(want.jobs_killed));
					if (got.overflow != want.overflow)
						report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
					if (got.total_missed != want.total_missed)
						report_mismatch("total_missed", got.total_missed, want.total_missed);
					if (got.total_completed != want.total_completed)
						report_mismatch("total_completed", got.total_completed,
							want.total_completed);
				end
			end
		end
		outstanding <= tick_results_due.size();
	end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the rate-monotonic tick scheduler: clock, reset, stimulus and verdict.
module testbench;

	localparam int TICK_TARGET   = 1350;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 40;
	localparam int IDLE_PCT      = 34;

	logic                           clk;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [rmts_pkg::IN_W-1:0]      s_axis_tdata;   // last_tick[0], pad
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [rmts_pkg::OUT_W-1:0]     m_axis_tdata;   // running_task, idle, job_finished,
	                                                // deadlines_missed, jobs_killed, overflow,
	                                                // total_missed, total_completed, pad
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [rmts_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rmts_pkg::CFG_W-1:0]     cfg_data;

	int   mismatches;
	int   outstanding;
	logic calm;
	int   ticks_sent;
	int   cycles;

	rate_monotonic_tick_scheduler uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	rmts_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: give up after a generous number of cycles
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Result side: random stalls, one long hold-off, steady during calm stretches
	initial begin
		int taken, hold_left;
		logic held;
		taken = 0;
		hold_left = 0;
		held = 1'b0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				taken++;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!held && taken >= 500) begin
				held = 1'b1;
				hold_left = 400;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Offer one tick beat, at times with a random gap in front of it
	task automatic send_tick(input logic last);
		if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(rmts_pkg::IN_W-1){1'b0}}, last};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		ticks_sent++;
	endtask

	// Stop offering ticks and wait until every result has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rmts_pkg::CFG_IDX_W-1:0] idx,
			input logic [rmts_pkg::CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Write the selected registers once the scheduler is idle
	task automatic configure(input logic [3:0] which,
			input logic [rmts_pkg::TCNT_W-1:0] tcount,
			input logic [rmts_pkg::CFG_W-1:0] periods,
			input logic [rmts_pkg::CFG_W-1:0] budgets,
			input logic [rmts_pkg::CFG_W-1:0] deadlines);
		drain();
		if (which[0])
			write_reg(rmts_pkg::REG_TASK_COUNT, {32'($urandom), 29'($urandom), tcount});
		if (which[1])
			write_reg(rmts_pkg::REG_PERIODS, periods);
		if (which[2])
			write_reg(rmts_pkg::REG_BUDGETS, budgets);
		if (which[3])
			write_reg(rmts_pkg::REG_DEADLINES, deadlines);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [rmts_pkg::TCNT_W-1:0] pick_task_count();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return rmts_pkg::TCNT_W'($urandom_range(5, 7));
		return rmts_pkg::TCNT_W'($urandom_range(1, 4));
	endfunction

	// Mostly small values, now and then zero, all ones or anything
	function automatic logic [rmts_pkg::FIELD_W-1:0] pick_field(input int lo, input int hi);
		int sel;
		sel = $urandom_range(0, 15);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		if (sel == 2)
			return rmts_pkg::FIELD_W'($urandom);
		return rmts_pkg::FIELD_W'($urandom_range(lo, hi));
	endfunction

	function automatic logic [rmts_pkg::CFG_W-1:0] pick_fields(input int lo, input int hi);
		return {pick_field(lo, hi), pick_field(lo, hi), pick_field(lo, hi), pick_field(lo, hi)};
	endfunction

	initial begin
		int phase, span, k;
		logic closing;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		cfg_valid     <= 1'b0;
		cfg_index     <= rmts_pkg::REG_TASK_COUNT;
		cfg_data      <= '0;
		calm          <= 1'b0;
		ticks_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Starting at time zero: a never-releasing task, a zero deadline,
		// a zero budget and a long period that fires only at time zero
		configure(4'hF, 3'd4, {16'hFFFF, 16'd0, 16'd3, 16'd2},
			{16'd0, 16'd5, 16'd2, 16'd1}, {16'd7, 16'd4, 16'd0, 16'd2});
		for (k = 0; k < 6; k++)
			send_tick(k == 5);

		// Oversized task count, period one, long jobs: fill the queue, overflow, flush all
		configure(4'hF, 3'd7, 64'h0001_0001_0001_0001, '1, '1);
		for (k = 0; k < 6; k++)
			send_tick(k == 5);

		// No task in use
		configure(4'h1, 3'd0, '0, '0, '0);
		for (k = 0; k < 2; k++)
			send_tick(k == 1);

		// Equal periods keep release order; jobs left queued across the phase end
		configure(4'hF, 3'd2, {16'd0, 16'd0, 16'd4, 16'd4},
			{16'd0, 16'd0, 16'd2, 16'd3}, {16'd0, 16'd0, 16'd16, 16'd16});
		for (k = 0; k < 6; k++)
			send_tick(1'b0);

		// Random phases, each rewriting a random selection of the registers
		phase = 0;
		while (ticks_sent < TICK_TARGET) begin
			configure(4'($urandom_range(1, 15)), pick_task_count(), pick_fields(1, 12),
				pick_fields(1, 5), pick_fields(1, 24));
			calm <= (phase >= 6 && phase < 9);
			span = $urandom_range(20, 70);
			closing = ($urandom_range(0, 3) != 0);
			for (k = 0; k < span; k++)
				send_tick((k == span - 1) ? closing : ($urandom_range(0, 39) == 0));
			phase++;
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: rate_monotonic_tick_scheduler.f
src/rmts_pkg.sv
src/rmts_cell.sv
src/rmts_residue.sv
src/rate_monotonic_tick_scheduler.sv
sim/rmts_checker.sv
sim/testbench.sv
